@@ design/mrnp_pkg.sv @@
// Package for the multi-resource node placement block.
// Holds widths, codes, reset constants and the shared entry/best types.
// Used by mrnp_best and multi_resource_node_placement; depends on nothing.
package mrnp_pkg;

	// Node table geometry
	localparam int NODES      = 128;
	localparam int NODE_W     = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int LAST_NODE  = NODES - 1;

	// Field widths
	localparam int CORE_W     = 6;
	localparam int MEM_W      = 8;
	localparam int SUM_W      = 9;
	localparam int IDX_OUT_W  = 7;
	localparam int TCORE_W    = 13;
	localparam int TMEM_W     = 15;
	localparam int PLACED_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int POLICY_W   = 2;

	// Reset capacities and saturation limits
	localparam logic [CORE_W-1:0]   CORE_CAP_RESET  = CORE_W'(24);
	localparam logic [MEM_W-1:0]    MEM_CAP_RESET   = MEM_W'(64);
	localparam logic [TCORE_W-1:0]  TOTAL_CORES_MAX = '1;
	localparam logic [TMEM_W-1:0]   TOTAL_MEM_MAX   = '1;
	localparam logic [PLACED_W-1:0] PLACED_MAX      = '1;

	// Item function codes
	localparam logic FUNC_PLACE  = 1'b0;
	localparam logic FUNC_NEWDAY = 1'b1;

	// Fit policy codes (the unused code acts as first fit)
	localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CORE_CAP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_CAP  = 2'd2;

	// One node table entry
	typedef struct packed {
		logic [CORE_W-1:0] cores;
		logic [MEM_W-1:0]  mem;
	} entry_t;

	// Running best candidate of a scan
	typedef struct packed {
		logic              found;
		logic [NODE_W-1:0] idx;
		entry_t            ent;
		logic [SUM_W-1:0]  sum;
	} best_t;

endpackage

@@ design/multi_resource_node_placement.sv @@
// Top level of the multi-resource node placement block: node table memory,
// scan sequencer, write-back, running totals and configuration registers.
// Depends on mrnp_pkg and mrnp_best.
//
// Channel  | Handshake          | Payload
// ---------+--------------------+-----------------------------------------------
// request  | start & !busy      | func, cores_needed, mem_needed
// result   | done (one cycle)   | granted, node_index, cores_in_use, mem_in_use,
//          |                    | placements
// config   | cfg_we             | cfg_index, cfg_wdata
//
// A placement runs from accept to result as follows: the node table is read
// one entry per cycle through its single read port, all 128 entries, then come
// the last compare, the write-back and the result beat in turn; busy drops
// when the write-back ends, so the next request can go in on the edge
// that ends the result beat. A new day clears all per-node valid bits at
// once, and unwritten entries read as the refill capacities latched
// at that moment. Reset acts as a new day with the reset capacities. The
// receiver cannot stall; busy holds off new requests.
module multi_resource_node_placement (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               func,
	input  logic [mrnp_pkg::CORE_W-1:0]        cores_needed,
	input  logic [mrnp_pkg::MEM_W-1:0]         mem_needed,
	output logic                               done,
	output logic                               granted,
	output logic [mrnp_pkg::IDX_OUT_W-1:0]     node_index,
	output logic [mrnp_pkg::TCORE_W-1:0]       cores_in_use,
	output logic [mrnp_pkg::TMEM_W-1:0]        mem_in_use,
	output logic [mrnp_pkg::PLACED_W-1:0]      placements,
	input  logic                               cfg_we,
	input  logic [mrnp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mrnp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import mrnp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

	state_t               state_q;
	logic                 accept;
	logic [NODE_W-1:0]    cnt_q;
	logic                 vld_s1;
	logic [NODE_W-1:0]    idx_s1;
	entry_t               ent_s1;
	logic                 vbit_s1;
	entry_t               eff_ent;
	logic [NODES-1:0]     vld_bits_q;
	entry_t               mem_q [NODES];
	best_t                best;
	logic                 wr_en;
	entry_t               wr_ent;

	logic [POLICY_W-1:0]  policy_q;
	logic [CORE_W-1:0]    core_cap_q;
	logic [MEM_W-1:0]     mem_cap_q;
	entry_t               fill_q;
	logic [CORE_W-1:0]    need_c_q;
	logic [MEM_W-1:0]     need_m_q;

	logic [TCORE_W-1:0]   tot_cores_q;
	logic [TMEM_W-1:0]    tot_mem_q;
	logic [PLACED_W-1:0]  placed_q;
	logic [TCORE_W:0]     tc_sum;
	logic [TMEM_W:0]      tm_sum;
	logic [PLACED_W:0]    pc_sum;

	logic                 done_q;
	logic                 granted_q;
	logic [IDX_OUT_W-1:0] node_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q   <= POL_FIRST;
			core_cap_q <= CORE_CAP_RESET;
			mem_cap_q  <= MEM_CAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POLICY:   policy_q   <= cfg_wdata[POLICY_W-1:0];
				CFG_CORE_CAP: core_cap_q <= cfg_wdata[CORE_W-1:0];
				CFG_MEM_CAP:  mem_cap_q  <= cfg_wdata[MEM_W-1:0];
				default:      ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && func == FUNC_PLACE) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cnt_q == NODE_W'(LAST_NODE)) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + NODE_W'(1);
					end
				end
				ST_DRAIN: state_q <= ST_WRITE;
				ST_WRITE: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Request latch
	always_ff @(posedge clk) begin
		if (accept) begin
			need_c_q <= cores_needed;
			need_m_q <= mem_needed;
		end
	end

	// Refill values and per-node valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '{cores: CORE_CAP_RESET, mem: MEM_CAP_RESET};
			vld_bits_q <= '0;
		end else if (accept && func == FUNC_NEWDAY) begin
			fill_q     <= '{cores: core_cap_q, mem: mem_cap_q};
			vld_bits_q <= '0;
		end else if (wr_en) begin
			vld_bits_q[best.idx] <= 1'b1;
		end
	end

	// Node table memory: one read port for the scan, one write port for the charge
	assign wr_en  = (state_q == ST_WRITE) && best.found;
	assign wr_ent = '{cores: best.ent.cores - need_c_q, mem: best.ent.mem - need_m_q};

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[best.idx] <= wr_ent;
		ent_s1  <= mem_q[cnt_q];
		vbit_s1 <= vld_bits_q[cnt_q];
		idx_s1  <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
		end
	end

	// Unwritten entries since the last refill read as the refill values
	assign eff_ent = vbit_s1 ? ent_s1 : fill_q;

	mrnp_best u_best (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (accept),
		.vld        (vld_s1),
		.idx        (idx_s1),
		.ent        (eff_ent),
		.cores_need (need_c_q),
		.mem_need   (need_m_q),
		.policy     (policy_q),
		.best       (best)
	);

	// Saturating totals
	assign tc_sum = (TCORE_W+1)'(tot_cores_q) + (TCORE_W+1)'(need_c_q);
	assign tm_sum = (TMEM_W+1)'(tot_mem_q) + (TMEM_W+1)'(need_m_q);
	assign pc_sum = (PLACED_W+1)'(placed_q) + (PLACED_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_cores_q <= '0;
			tot_mem_q   <= '0;
			placed_q    <= '0;
		end else if (accept && func == FUNC_NEWDAY) begin
			tot_cores_q <= '0;
			tot_mem_q   <= '0;
			placed_q    <= '0;
		end else if (wr_en) begin
			tot_cores_q <= tc_sum[TCORE_W] ? TOTAL_CORES_MAX : tc_sum[TCORE_W-1:0];
			tot_mem_q   <= tm_sum[TMEM_W] ? TOTAL_MEM_MAX : tm_sum[TMEM_W-1:0];
			placed_q    <= pc_sum[PLACED_W] ? PLACED_MAX : pc_sum[PLACED_W-1:0];
		end
	end

	// Result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			granted_q <= 1'b0;
			node_q    <= '0;
		end else begin
			done_q    <= (accept && func == FUNC_NEWDAY) || (state_q == ST_WRITE);
			granted_q <= wr_en;
			node_q    <= wr_en ? IDX_OUT_W'(best.idx) : '0;
		end
	end

	assign done         = done_q;
	assign granted      = granted_q;
	assign node_index   = node_q;
	assign cores_in_use = tot_cores_q;
	assign mem_in_use   = tot_mem_q;
	assign placements   = placed_q;

	// A result beat follows either a write-back or a new-day accept
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_WRITE) ||
			($past(start) && !$past(busy) && $past(func) == FUNC_NEWDAY))
		else $error("result beat without a finished item");

	// A grant only appears on a result beat, and ungranted results carry node 0
	a_grant_done: assert property (@(posedge clk) disable iff (!arst_n)
		granted |-> done)
		else $error("grant outside a result beat");

	a_nogrant_node: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !granted) |-> (node_index == '0))
		else $error("nonzero node index without grant");

	// A grant bumps the placement count unless it is saturated
	a_grant_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && best.found) |=>
			(placements == PLACED_MAX) || (placements == $past(placements) + PLACED_W'(1)))
		else $error("placement count did not advance on grant");

endmodule

@@ design/mrnp_best.sv @@
// Candidate tracker for the node scan: checks one entry per beat against
// the request and keeps the node chosen by the fit policy.
// Depends on mrnp_pkg.
module mrnp_best (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clear,
	input  logic                            vld,
	input  logic [mrnp_pkg::NODE_W-1:0]     idx,
	input  mrnp_pkg::entry_t                ent,
	input  logic [mrnp_pkg::CORE_W-1:0]     cores_need,
	input  logic [mrnp_pkg::MEM_W-1:0]      mem_need,
	input  logic [mrnp_pkg::POLICY_W-1:0]   policy,
	output mrnp_pkg::best_t                 best
);
	import mrnp_pkg::*;

	logic              found_q;
	logic [NODE_W-1:0] idx_q;
	entry_t            ent_q;
	logic [SUM_W-1:0]  sum_q;
	logic              fits;
	logic              take;
	logic [SUM_W-1:0]  sum;

	// Fit test and policy decision; scan order is ascending so ties keep the low index
	always_comb begin
		sum  = SUM_W'(ent.cores) + SUM_W'(ent.mem);
		fits = (ent.cores >= cores_need) && (ent.mem >= mem_need);
		unique case (policy)
			POL_BEST:  take = !found_q || (sum < sum_q);
			POL_WORST: take = !found_q || (sum > sum_q);
			default:   take = !found_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
		end else if (vld && fits && take) begin
			found_q <= 1'b1;
		end
	end

	// Payload of the candidate, no reset needed
	always_ff @(posedge clk) begin
		if (vld && fits && take && !clear) begin
			idx_q <= idx;
			ent_q <= ent;
			sum_q <= sum;
		end
	end

	assign best = '{found: found_q, idx: idx_q, ent: ent_q, sum: sum_q};

endmodule
